// ----- rtl/core/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray / triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int PACKED_W  = 63;  // packed x,y,z vector beat field
  localparam int THR_W     = 16;  // cull threshold register
  localparam int DIST_W    = 32;  // hit distance
  localparam int BARY_FRAC = 20;  // barycentric fraction bits
  localparam int BARY_W    = BARY_FRAC + 1;
  localparam int T_Q_BITS  = 32;  // stored quotient bits of t

  localparam logic [BARY_W-1:0] BARY_ONE = BARY_W'(1) << BARY_FRAC;
  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_CAMERA  = 2'd0,
    KIND_REFLECT = 2'd1,
    KIND_SHADOW  = 2'd2,
    KIND_OTHER   = 2'd3
  } ray_kind_e;

  // status that rides along the divider stages
  typedef struct packed {
    logic hit;
    logic t_neg;
    logic t_ovf;
  } rti_flags_t;

endpackage

// ----- rtl/core/rti_ifs.sv -----
// ----------------------------------------------------------------------------
// rti_ifs
// Valid/ready channels of the intersection block: request, result, config.
// ----------------------------------------------------------------------------
interface rti_req_if import rti_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PACKED_W-1:0] ray_origin;
  logic [PACKED_W-1:0] ray_direction;
  logic [1:0]          ray_kind;
  logic [PACKED_W-1:0] vertex0;
  logic [PACKED_W-1:0] vertex1;
  logic [PACKED_W-1:0] vertex2;

  modport source (output valid, ray_origin, ray_direction, ray_kind,
                  vertex0, vertex1, vertex2, input ready);
  modport sink   (input valid, ray_origin, ray_direction, ray_kind,
                  vertex0, vertex1, vertex2, output ready);
endinterface

interface rti_res_if import rti_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DIST_W-1:0] hit_distance;
  logic [BARY_W-1:0]        bary_u;
  logic [BARY_W-1:0]        bary_v;

  modport source (output valid, hit, hit_distance, bary_u, bary_v, input ready);
  modport sink   (input valid, hit, hit_distance, bary_u, bary_v, output ready);
endinterface

interface rti_cfg_if import rti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] cull_threshold;

  modport source (output valid, cull_threshold, input ready);
  modport sink   (input valid, cull_threshold, output ready);
endinterface

// ----- rtl/core/ray_triangle_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Fully pipelined exact fixed-point ray / triangle hit test.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     beat contents
//   req_i    in   valid/ready   ray origin, direction, kind, three vertices
//   res_o    out  valid/ready   hit, distance t, barycentric u and v
//   cfg_i    in   valid/ready   cull threshold (ready is always high)
//
// One beat per cycle sustained while res_o accepts; stages: 4 geometry
// stages, 1 classify stage, 33 division stages (an overflow check, then
// one quotient bit each), 1 output register; the t divider sets the depth.
// Reset clears all stage valid bits and the threshold; payload is not reset.
// Each stage holds while its successor is full, so a stall at res_o backs
// up stage by stage; empty stages keep filling meanwhile.
// ----------------------------------------------------------------------------
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rti_req_if.sink  req_i,
  rti_res_if.source res_o,
  rti_cfg_if.sink  cfg_i
);

  localparam int DW    = 3 * COORD_WIDTH + 6;   // exact dot-product width
  localparam int TW    = DW + T_Q_BITS + 1;     // t remainder
  localparam int UW    = DW + BARY_W;           // u, v remainders
  localparam int NSTEP = T_Q_BITS + 1;          // overflow step plus 32 bits

  // --- threshold register --------------------------------------------------
  logic [THR_W-1:0] thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      thr_q <= cfg_i.cull_threshold;
    end
  end

  // --- geometry front end --------------------------------------------------
  logic                 g_valid, g_ready;
  ray_kind_e            g_kind;
  logic signed [DW-1:0] g_det, g_un, g_vn, g_tn;

  rti_geom #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (req_i.valid),
    .ready_o  (req_i.ready),
    .origin_i (req_i.ray_origin),
    .dir_i    (req_i.ray_direction),
    .kind_i   (ray_kind_e'(req_i.ray_kind)),
    .v0_i     (req_i.vertex0),
    .v1_i     (req_i.vertex1),
    .v2_i     (req_i.vertex2),
    .valid_o  (g_valid),
    .ready_i  (g_ready),
    .kind_o   (g_kind),
    .det_o    (g_det),
    .un_o     (g_un),
    .vn_o     (g_vn),
    .tn_o     (g_tn)
  );

  // --- hit tests -----------------------------------------------------------
  logic          c_valid;
  rti_flags_t    c_flags;
  logic [DW-1:0] c_den, c_un, c_vn, c_tn;

  // divider chain nets, index s feeds step s
  logic                vld_w   [NSTEP+1];
  logic                rdy_w   [NSTEP+1];
  rti_flags_t          flags_w [NSTEP+1];
  logic [DW-1:0]       den_w   [NSTEP+1];
  logic [TW-1:0]       rt_w    [NSTEP+1];
  logic [T_Q_BITS-1:0] qt_w    [NSTEP+1];
  logic [UW-1:0]       ru_w    [NSTEP+1];
  logic [UW-1:0]       rv_w    [NSTEP+1];
  logic [BARY_W-1:0]   qu_w    [NSTEP+1];
  logic [BARY_W-1:0]   qv_w    [NSTEP+1];

  rti_classify #(
    .DW (DW)
  ) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid),
    .ready_o (g_ready),
    .kind_i  (g_kind),
    .thr_i   (thr_q),
    .det_i   (g_det),
    .un_i    (g_un),
    .vn_i    (g_vn),
    .tn_i    (g_tn),
    .valid_o (c_valid),
    .ready_i (rdy_w[0]),
    .flags_o (c_flags),
    .den_o   (c_den),
    .un_o    (c_un),
    .vn_o    (c_vn),
    .tn_o    (c_tn)
  );

  // scaled numerators enter the divider
  assign vld_w[0]   = c_valid;
  assign flags_w[0] = c_flags;
  assign den_w[0]   = c_den;
  assign rt_w[0]    = TW'(c_tn) << FRAC_BITS;
  assign qt_w[0]    = '0;
  assign ru_w[0]    = UW'(c_un) << BARY_FRAC;
  assign rv_w[0]    = UW'(c_vn) << BARY_FRAC;
  assign qu_w[0]    = '0;
  assign qv_w[0]    = '0;

  // --- division pipeline ---------------------------------------------------
  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    rti_div_step #(
      .DW   (DW),
      .STEP (s)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[s]),
      .ready_o (rdy_w[s]),
      .flags_i (flags_w[s]),
      .den_i   (den_w[s]),
      .rt_i    (rt_w[s]),
      .qt_i    (qt_w[s]),
      .ru_i    (ru_w[s]),
      .rv_i    (rv_w[s]),
      .qu_i    (qu_w[s]),
      .qv_i    (qv_w[s]),
      .valid_o (vld_w[s+1]),
      .ready_i (rdy_w[s+1]),
      .flags_o (flags_w[s+1]),
      .den_o   (den_w[s+1]),
      .rt_o    (rt_w[s+1]),
      .qt_o    (qt_w[s+1]),
      .ru_o    (ru_w[s+1]),
      .rv_o    (rv_w[s+1]),
      .qu_o    (qu_w[s+1]),
      .qv_o    (qv_w[s+1])
    );
  end

  // --- saturation, miss zeroing, output register ---------------------------
  rti_flags_t          f_fin;
  logic [T_Q_BITS-1:0] q_fin;
  logic                pos_sat, neg_sat;
  logic [DIST_W-1:0]   dist_d;
  logic                out_v_q;

  assign f_fin   = flags_w[NSTEP];
  assign q_fin   = qt_w[NSTEP];
  // positive t tops out at 2^31-1, negative at -2^31
  assign pos_sat = f_fin.t_ovf || q_fin[T_Q_BITS-1];
  assign neg_sat = f_fin.t_ovf || (q_fin[T_Q_BITS-1] && (q_fin[T_Q_BITS-2:0] != '0));

  always_comb begin
    if (f_fin.t_neg) begin
      dist_d = neg_sat ? DIST_MIN : DIST_W'(-q_fin);
    end else begin
      dist_d = pos_sat ? DIST_MAX : DIST_W'(q_fin);
    end
  end

  assign rdy_w[NSTEP] = !out_v_q || res_o.ready;
  assign res_o.valid  = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy_w[NSTEP]) begin
      out_v_q <= vld_w[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_w[NSTEP]) begin
      res_o.hit          <= f_fin.hit;
      res_o.hit_distance <= f_fin.hit ? dist_d : '0;
      res_o.bary_u       <= f_fin.hit ? qu_w[NSTEP] : '0;
      res_o.bary_v       <= f_fin.hit ? qv_w[NSTEP] : '0;
    end
  end

  // --- assertions ----------------------------------------------------------
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit |->
      res_o.hit_distance == '0 && res_o.bary_u == '0 && res_o.bary_v == '0)
    else $error("miss beat carries nonzero fields");

  a_bary_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.hit |->
      ((BARY_W+1)'(res_o.bary_u) + (BARY_W+1)'(res_o.bary_v)) <= (BARY_W+1)'(BARY_ONE))
    else $error("u + v above one on a hit");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> req_i.ready)
    else $error("input stalled with empty output stage");

endmodule

// ----- rtl/core/rti_geom.sv -----
// ----------------------------------------------------------------------------
// rti_geom
// Four-stage front end: edges, cross products, dot products, sums.
// ----------------------------------------------------------------------------
module rti_geom import rti_pkg::*; #(
  parameter int COORD_WIDTH = 21,
  localparam int DW = 3 * COORD_WIDTH + 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [PACKED_W-1:0]   origin_i,
  input  logic [PACKED_W-1:0]   dir_i,
  input  ray_kind_e             kind_i,
  input  logic [PACKED_W-1:0]   v0_i,
  input  logic [PACKED_W-1:0]   v1_i,
  input  logic [PACKED_W-1:0]   v2_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ray_kind_e             kind_o,
  output logic signed [DW-1:0]  det_o,
  output logic signed [DW-1:0]  un_o,
  output logic signed [DW-1:0]  vn_o,
  output logic signed [DW-1:0]  tn_o
);

  localparam int W  = COORD_WIDTH;
  localparam int EW = W + 1;
  localparam int CW = 2 * EW + 1;
  localparam int PW = CW + EW;

  logic [3:0] v_q;
  logic [3:0] rdy;
  ray_kind_e  kind_q [4];

  assign rdy[3]  = !v_q[3] || ready_i;
  assign rdy[2]  = !v_q[2] || rdy[3];
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = v_q[3];
  assign kind_o  = kind_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  // stage A: unpack, edges and origin offset
  logic signed [W-1:0]  o_c [3];
  logic signed [W-1:0]  d_c [3];
  logic signed [W-1:0]  a_c [3];
  logic signed [W-1:0]  b_c [3];
  logic signed [W-1:0]  c_c [3];
  logic signed [W-1:0]  d_a_q  [3];
  logic signed [EW-1:0] e1_a_q [3];
  logic signed [EW-1:0] e2_a_q [3];
  logic signed [EW-1:0] tv_a_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      o_c[k] = origin_i[k*W +: W];
      d_c[k] = dir_i[k*W +: W];
      a_c[k] = v0_i[k*W +: W];
      b_c[k] = v1_i[k*W +: W];
      c_c[k] = v2_i[k*W +: W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      kind_q[0] <= kind_i;
      for (int k = 0; k < 3; k++) begin
        d_a_q[k]  <= d_c[k];
        e1_a_q[k] <= EW'(b_c[k]) - EW'(a_c[k]);
        e2_a_q[k] <= EW'(c_c[k]) - EW'(a_c[k]);
        tv_a_q[k] <= EW'(o_c[k]) - EW'(a_c[k]);
      end
    end
  end

  // stage B: P = D x e2, Q = T x e1
  logic signed [2*EW-1:0] mp [6];
  logic signed [2*EW-1:0] mq [6];
  logic signed [EW-1:0]   d_b_q  [3];
  logic signed [EW-1:0]   e1_b_q [3];
  logic signed [EW-1:0]   e2_b_q [3];
  logic signed [EW-1:0]   tv_b_q [3];
  logic signed [CW-1:0]   p_b_q  [3];
  logic signed [CW-1:0]   q_b_q  [3];

  always_comb begin
    mp[0] = d_a_q[1] * e2_a_q[2];
    mp[1] = d_a_q[2] * e2_a_q[1];
    mp[2] = d_a_q[2] * e2_a_q[0];
    mp[3] = d_a_q[0] * e2_a_q[2];
    mp[4] = d_a_q[0] * e2_a_q[1];
    mp[5] = d_a_q[1] * e2_a_q[0];
    mq[0] = tv_a_q[1] * e1_a_q[2];
    mq[1] = tv_a_q[2] * e1_a_q[1];
    mq[2] = tv_a_q[2] * e1_a_q[0];
    mq[3] = tv_a_q[0] * e1_a_q[2];
    mq[4] = tv_a_q[0] * e1_a_q[1];
    mq[5] = tv_a_q[1] * e1_a_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      kind_q[1] <= kind_q[0];
      for (int k = 0; k < 3; k++) begin
        d_b_q[k]  <= EW'(d_a_q[k]);
        e1_b_q[k] <= e1_a_q[k];
        e2_b_q[k] <= e2_a_q[k];
        tv_b_q[k] <= tv_a_q[k];
        p_b_q[k]  <= CW'(mp[2*k]) - CW'(mp[2*k+1]);
        q_b_q[k]  <= CW'(mq[2*k]) - CW'(mq[2*k+1]);
      end
    end
  end

  // stage C: the twelve dot-product terms
  logic signed [PW-1:0] pr_q [12];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      kind_q[2] <= kind_q[1];
      for (int k = 0; k < 3; k++) begin
        pr_q[k]     <= p_b_q[k] * e1_b_q[k];
        pr_q[3 + k] <= tv_b_q[k] * p_b_q[k];
        pr_q[6 + k] <= d_b_q[k] * q_b_q[k];
        pr_q[9 + k] <= e2_b_q[k] * q_b_q[k];
      end
    end
  end

  // stage D: det and the numerators
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      kind_q[3] <= kind_q[2];
      det_o <= DW'(pr_q[0]) + DW'(pr_q[1]) + DW'(pr_q[2]);
      un_o  <= DW'(pr_q[3]) + DW'(pr_q[4]) + DW'(pr_q[5]);
      vn_o  <= DW'(pr_q[6]) + DW'(pr_q[7]) + DW'(pr_q[8]);
      tn_o  <= DW'(pr_q[9]) + DW'(pr_q[10]) + DW'(pr_q[11]);
    end
  end

endmodule

// ----- rtl/core/rti_classify.sv -----
// ----------------------------------------------------------------------------
// rti_classify
// Sign normalization and exact hit tests on det and the numerators.
// ----------------------------------------------------------------------------
module rti_classify import rti_pkg::*; #(
  parameter int DW = 69
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  ray_kind_e            kind_i,
  input  logic [THR_W-1:0]     thr_i,
  input  logic signed [DW-1:0] det_i,
  input  logic signed [DW-1:0] un_i,
  input  logic signed [DW-1:0] vn_i,
  input  logic signed [DW-1:0] tn_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rti_flags_t           flags_o,
  output logic [DW-1:0]        den_o,
  output logic [DW-1:0]        un_o,
  output logic [DW-1:0]        vn_o,
  output logic [DW-1:0]        tn_o
);

  localparam int XW = DW + 2;

  logic signed [XW-1:0] det_x, un_x, vn_x, tn_x, thr_x;
  logic signed [XW-1:0] det_a, un_a, vn_a, tn_a, tn_m, sum_uv;
  logic                 det_neg, cull, range_miss, shadow_miss;
  logic                 v_q;
  rti_flags_t           flags_d;

  always_comb begin
    det_x   = XW'(det_i);
    un_x    = XW'(un_i);
    vn_x    = XW'(vn_i);
    tn_x    = XW'(tn_i);
    thr_x   = XW'(thr_i);
    det_neg = det_i[DW-1];
    det_a   = det_neg ? -det_x : det_x;
    un_a    = det_neg ? -un_x  : un_x;
    vn_a    = det_neg ? -vn_x  : vn_x;
    tn_a    = det_neg ? -tn_x  : tn_x;
    tn_m    = tn_a[XW-1] ? -tn_a : tn_a;
    sum_uv  = un_a + vn_a;
    // camera and reflection rays cull at or below the threshold
    cull = (kind_i == KIND_CAMERA || kind_i == KIND_REFLECT) && (det_x <= thr_x);
    range_miss = un_a[XW-1] || (un_a > det_a) || vn_a[XW-1] || (sum_uv > det_a);
    shadow_miss = (kind_i == KIND_SHADOW) && (tn_a[XW-1] || (tn_a == '0));
    flags_d.hit   = !(cull || (det_i == '0) || range_miss || shadow_miss);
    flags_d.t_neg = tn_a[XW-1];
    flags_d.t_ovf = 1'b0;
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      flags_o <= flags_d;
      den_o   <= det_a[DW-1:0];
      un_o    <= un_a[DW-1:0];
      vn_o    <= vn_a[DW-1:0];
      tn_o    <= tn_m[DW-1:0];
    end
  end

endmodule

// ----- rtl/core/rti_div_step.sv -----
// ----------------------------------------------------------------------------
// rti_div_step
// One registered restoring-division step for t, and for u and v early on.
// ----------------------------------------------------------------------------
module rti_div_step import rti_pkg::*; #(
  parameter int DW   = 69,
  parameter int STEP = 0,
  localparam int TW  = DW + T_Q_BITS + 1,
  localparam int UW  = DW + BARY_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  rti_flags_t          flags_i,
  input  logic [DW-1:0]       den_i,
  input  logic [TW-1:0]       rt_i,
  input  logic [T_Q_BITS-1:0] qt_i,
  input  logic [UW-1:0]       ru_i,
  input  logic [UW-1:0]       rv_i,
  input  logic [BARY_W-1:0]   qu_i,
  input  logic [BARY_W-1:0]   qv_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rti_flags_t          flags_o,
  output logic [DW-1:0]       den_o,
  output logic [TW-1:0]       rt_o,
  output logic [T_Q_BITS-1:0] qt_o,
  output logic [UW-1:0]       ru_o,
  output logic [UW-1:0]       rv_o,
  output logic [BARY_W-1:0]   qu_o,
  output logic [BARY_W-1:0]   qv_o
);

  localparam int I_T = T_Q_BITS - STEP;
  localparam int I_U = BARY_FRAC - STEP;

  rti_flags_t          flags_d;
  logic [TW-1:0]       rt_d, dt;
  logic [T_Q_BITS-1:0] qt_d;
  logic [UW-1:0]       ru_d, rv_d;
  logic [BARY_W-1:0]   qu_d, qv_d;
  logic                ge_t;
  logic                v_q;

  assign dt   = TW'(den_i) << I_T;
  assign ge_t = rt_i >= dt;

  if (STEP == 0) begin : g_ovf
    // first step only flags a quotient of 2^32 or more
    always_comb begin
      flags_d       = flags_i;
      flags_d.t_ovf = ge_t;
      rt_d          = rt_i;
      qt_d          = qt_i;
    end
  end else begin : g_tbit
    always_comb begin
      flags_d   = flags_i;
      rt_d      = ge_t ? rt_i - dt : rt_i;
      qt_d      = qt_i;
      qt_d[I_T] = ge_t;
    end
  end

  if (STEP <= BARY_FRAC) begin : g_uv
    logic [UW-1:0] du;
    logic          ge_u, ge_v;
    always_comb begin
      du       = UW'(den_i) << I_U;
      ge_u     = ru_i >= du;
      ge_v     = rv_i >= du;
      ru_d     = ge_u ? ru_i - du : ru_i;
      rv_d     = ge_v ? rv_i - du : rv_i;
      qu_d     = qu_i;
      qv_d     = qv_i;
      qu_d[I_U] = ge_u;
      qv_d[I_U] = ge_v;
    end
  end else begin : g_uv_done
    always_comb begin
      ru_d = ru_i;
      rv_d = rv_i;
      qu_d = qu_i;
      qv_d = qv_i;
    end
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      flags_o <= flags_d;
      den_o   <= den_i;
      rt_o    <= rt_d;
      qt_o    <= qt_d;
      ru_o    <= ru_d;
      rv_o    <= rv_d;
      qu_o    <= qu_d;
      qv_o    <= qv_d;
    end
  end

endmodule
